// ===== hdl/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

    // Fixed field widths of the command and result words
    localparam int ADDR_W = 12;
    localparam int REQ_W  = 13;
    // Block size in granules asked for by an allocate: ceil(req / 8) + 2
    localparam int NEED_W = 11;

    // Granule geometry and boundary-tag rules
    localparam int GRANULE_BYTES      = 8;
    localparam int GRANULE_SHIFT      = 3;
    localparam int TAG_GRANULES       = 2;
    localparam int MIN_SPLIT_GRANULES = 3;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Control sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_HEAD,
        ST_TAIL
    } t_state;

endpackage

// ===== hdl/first_fit_block_allocator.sv =====
// Top level of the first-fit boundary-tag heap allocator.
//
// A command word is taken when start is high and busy is low. Every command gives exactly
// one result word, shown for one cycle with o_done high; the receiver cannot hold it off.
// Allocate walks the block chain from offset 0 through the tag RAM, one block header per
// cycle on its single read port, until a block fits or the chain ends. A block that fits
// gets its header and then its trailer written, then on a split those of the free
// remainder; o_done is high in the first cycle with busy low again, and a new word can
// be taken in that same cycle. A release walks the same way until it reaches the matching
// payload offset, and writes header and trailer when it clears the in-use bit.
// After reset the block is busy while it writes the header and trailer of the single free
// block that spans the heap; only block headers are ever read, so no other entry needs
// clearing.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int HEAP_BYTES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cmd,
    input  logic [REQ_W-1:0]  i_req_bytes,
    input  logic [ADDR_W-1:0] i_free_addr,
    output logic              o_done,
    output logic [ADDR_W-1:0] o_alloc_addr,
    output logic              o_fail
);

    localparam int GRANULES = HEAP_BYTES / GRANULE_BYTES;
    localparam int AW       = $clog2(GRANULES);
    localparam int GW       = $clog2(GRANULES + 1);
    localparam int TW       = GW + 1;
    localparam int SW       = GW + 1;
    localparam int CW       = (GW > NEED_W) ? GW : NEED_W;
    localparam int PW       = (GW + GRANULE_SHIFT > ADDR_W) ? GW + GRANULE_SHIFT : ADDR_W;

    // Registers
    t_state            r_state, n_state;
    logic [AW-1:0]     r_walk_ptr, n_walk_ptr;
    logic              r_cmd, n_cmd;
    logic [NEED_W-1:0] r_need, n_need;
    logic [ADDR_W-1:0] r_faddr, n_faddr;
    logic [GW-1:0]     r_blk_sz, n_blk_sz;
    logic [GW-1:0]     r_rem_sz, n_rem_sz;
    logic              r_used, n_used;
    logic              r_split, n_split;
    logic              r_report, n_report;
    logic              r_done, n_done;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_fail, n_fail;

    // Tag RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [TW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [TW-1:0] rd_tag;

    // Walk datapath
    logic [GW-1:0]    tag_sz;
    logic             tag_used;
    logic [SW-1:0]    next_ptr;
    logic             past_end;
    logic [CW-1:0]    spare;
    logic             fits;
    logic             split;
    logic [SW-1:0]    pay_gran;
    logic [PW-1:0]    pay;
    logic [PW-1:0]    faddr_ext;
    logic [SW-1:0]    tail_ptr;
    logic [SW-1:0]    rem_ptr;
    logic [REQ_W:0]   req_sum;

    ffba_tag_ram #(
        .DEPTH(GRANULES),
        .AW   (AW),
        .DW   (TW)
    ) u_tag_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(rd_tag)
    );

    // Decode the header that arrived for r_walk_ptr
    assign tag_sz    = rd_tag[TW-1:1];
    assign tag_used  = rd_tag[0];
    assign next_ptr  = SW'(r_walk_ptr) + SW'(tag_sz);
    assign past_end  = next_ptr >= SW'(GRANULES);
    assign fits      = !tag_used && (CW'(tag_sz) >= CW'(r_need));
    assign spare     = CW'(tag_sz) - CW'(r_need);
    assign split     = spare >= CW'(MIN_SPLIT_GRANULES);
    assign pay_gran  = SW'(r_walk_ptr) + SW'(1);
    assign pay       = PW'(pay_gran) << GRANULE_SHIFT;
    assign faddr_ext = PW'(r_faddr);
    assign tail_ptr  = SW'(r_walk_ptr) + SW'(r_blk_sz) - SW'(1);
    assign rem_ptr   = SW'(r_walk_ptr) + SW'(r_blk_sz);
    assign req_sum   = (REQ_W + 1)'(i_req_bytes) + (REQ_W + 1)'(GRANULE_BYTES - 1);

    assign busy = (r_state != ST_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (tag_sz == '0) begin
                    n_state = ST_IDLE;
                end else if (r_cmd == CMD_ALLOC) begin
                    if (fits) begin
                        n_state = ST_HEAD;
                    end else if (past_end) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    if (pay > faddr_ext) begin
                        n_state = ST_IDLE;
                    end else if (pay == faddr_ext) begin
                        n_state = tag_used ? ST_HEAD : ST_IDLE;
                    end else if (past_end) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_HEAD: begin
                n_state = ST_TAIL;
            end
            ST_TAIL: begin
                n_state = r_split ? ST_HEAD : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and result
    always_comb begin
        n_walk_ptr = r_walk_ptr;
        n_cmd      = r_cmd;
        n_need     = r_need;
        n_faddr    = r_faddr;
        n_blk_sz   = r_blk_sz;
        n_rem_sz   = r_rem_sz;
        n_used     = r_used;
        n_split    = r_split;
        n_report   = r_report;
        n_done     = 1'b0;
        n_addr     = r_addr;
        n_fail     = r_fail;
        ram_we     = 1'b0;
        ram_waddr  = r_walk_ptr;
        ram_wdata  = {r_blk_sz, r_used};
        ram_raddr  = '0;
        case (r_state)
            ST_IDLE: begin
                // Latch the command word and fetch the first header
                if (start) begin
                    n_cmd      = i_cmd;
                    n_need     = NEED_W'(req_sum >> GRANULE_SHIFT) + NEED_W'(TAG_GRANULES);
                    n_faddr    = i_free_addr;
                    n_walk_ptr = '0;
                    n_addr     = '0;
                    n_fail     = 1'b0;
                    n_report   = 1'b1;
                    n_split    = 1'b0;
                end
            end
            ST_WALK: begin
                ram_raddr = next_ptr[AW-1:0];
                if (tag_sz == '0) begin
                    n_fail = (r_cmd == CMD_ALLOC);
                    n_done = 1'b1;
                end else if (r_cmd == CMD_ALLOC) begin
                    if (fits) begin
                        n_addr   = pay[ADDR_W-1:0];
                        n_used   = 1'b1;
                        n_split  = split;
                        n_blk_sz = split ? GW'(r_need) : tag_sz;
                        n_rem_sz = GW'(spare);
                    end else if (past_end) begin
                        n_fail = 1'b1;
                        n_done = 1'b1;
                    end else begin
                        n_walk_ptr = next_ptr[AW-1:0];
                    end
                end else begin
                    if (pay > faddr_ext) begin
                        n_done = 1'b1;
                    end else if (pay == faddr_ext) begin
                        n_blk_sz = tag_sz;
                        n_used   = 1'b0;
                        n_split  = 1'b0;
                        n_done   = !tag_used;
                    end else if (past_end) begin
                        n_done = 1'b1;
                    end else begin
                        n_walk_ptr = next_ptr[AW-1:0];
                    end
                end
            end
            ST_HEAD: begin
                ram_we    = 1'b1;
                ram_waddr = r_walk_ptr;
            end
            ST_TAIL: begin
                ram_we    = 1'b1;
                ram_waddr = tail_ptr[AW-1:0];
                if (r_split) begin
                    // Move on to the free remainder
                    n_walk_ptr = rem_ptr[AW-1:0];
                    n_blk_sz   = r_rem_sz;
                    n_used     = 1'b0;
                    n_split    = 1'b0;
                end else begin
                    n_done = r_report;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Control registers; reset loads the tag writes of the initial free block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_HEAD;
            r_walk_ptr <= '0;
            r_blk_sz   <= GW'(GRANULES);
            r_used     <= 1'b0;
            r_split    <= 1'b0;
            r_report   <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_walk_ptr <= n_walk_ptr;
            r_blk_sz   <= n_blk_sz;
            r_used     <= n_used;
            r_split    <= n_split;
            r_report   <= n_report;
            r_done     <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_need   <= n_need;
        r_faddr  <= n_faddr;
        r_rem_sz <= n_rem_sz;
        r_addr   <= n_addr;
        r_fail   <= n_fail;
    end

    assign o_done       = r_done;
    assign o_alloc_addr = r_addr;
    assign o_fail       = r_fail;

endmodule

// ===== hdl/ffba_tag_ram.sv =====
// Tag memory: one write port, one read port, registered read data.
module ffba_tag_ram
    import ffba_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ffba_checker.sv =====
// Port-level checks for the first-fit block allocator, bound to the top level.
module ffba_checker
    import ffba_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input logic [ADDR_W-1:0] o_alloc_addr,
    input logic              o_fail
);

    // Reset leaves the block busy writing the initial tags, with no result
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy && !o_done)
        else $error("block not busy after reset");

    // An accepted command word starts a walk, leaving the block busy with no result
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_done)
        else $error("accepted word did not start a walk");

    // The result strobe is never high twice in a row
    a_single_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe repeated");

    // A failed allocate returns offset zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_fail |-> o_alloc_addr == '0)
        else $error("failed allocate returned an offset");

    // Payload offsets sit on granule boundaries
    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_alloc_addr[GRANULE_SHIFT-1:0] == '0)
        else $error("payload offset not granule aligned");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_alloc_addr(o_alloc_addr),
    .o_fail      (o_fail)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the first-fit block allocator: directed heap cases, then random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffba_pkg::*;

    localparam int HEAP_BYTES     = 4096;
    localparam int GRANULES       = HEAP_BYTES / GRANULE_BYTES;
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_WORDS   = 480;
    localparam int DRAIN_CYCLES   = 16;
    // Longest sender gap plus a walk over a chain of minimum-size blocks, taken several times over
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [ADDR_W-1:0] alloc_addr;
        logic              fail;
    } t_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_cmd;
    logic [REQ_W-1:0]  i_req_bytes;
    logic [ADDR_W-1:0] i_free_addr;
    logic              o_done;
    logic [ADDR_W-1:0] o_alloc_addr;
    logic              o_fail;

    // Shadow copy of the boundary tags, one per granule
    logic [15:0]       heap_tags [GRANULES];
    t_reply            predicted_replies [$];
    logic [ADDR_W-1:0] live_blocks [$];
    logic [ADDR_W-1:0] released_blocks [$];

    int  mismatches = 0;
    int  stall_cycles = 0;
    int  n_granted = 0;
    int  n_refused = 0;
    int  n_releases = 0;
    int  n_freed = 0;
    bit  no_idle = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    first_fit_block_allocator #(
        .HEAP_BYTES(HEAP_BYTES)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_req_bytes (i_req_bytes),
        .i_free_addr (i_free_addr),
        .o_done      (o_done),
        .o_alloc_addr(o_alloc_addr),
        .o_fail      (o_fail)
    );

    // Header and trailer get the same tag; a trailer past the heap end is dropped
    function automatic void write_tag(int unsigned at, int unsigned blk_size, logic used);
        logic [15:0] tag;
        int unsigned tail;
        tag  = 16'((blk_size << 1) | used);
        tail = at + blk_size - 1;
        if (at < GRANULES) heap_tags[at] = tag;
        if (blk_size != 0 && tail < GRANULES) heap_tags[tail] = tag;
    endfunction

    function automatic void reset_heap();
        foreach (heap_tags[i]) heap_tags[i] = '0;
        write_tag(0, GRANULES, 1'b0);
    endfunction

    // Walk the block chain from offset 0 and apply one allocate or release
    function automatic t_reply heap_apply(logic cmd, logic [REQ_W-1:0] req,
                                          logic [ADDR_W-1:0] addr);
        t_reply      reply;
        int unsigned need;
        int unsigned cur;
        int unsigned blk_size;
        int unsigned pay;
        logic [15:0] tag;
        reply = '0;
        cur   = 0;
        if (cmd == CMD_ALLOC) begin
            need = (32'(req) + GRANULE_BYTES - 1) / GRANULE_BYTES + TAG_GRANULES;
            while (cur < GRANULES) begin
                tag      = heap_tags[cur];
                blk_size = 32'(tag >> 1);
                // zero-size tag ends the walk like the heap end
                if (blk_size == 0) break;
                if (!tag[0] && blk_size >= need) begin
                    if (blk_size - need >= MIN_SPLIT_GRANULES) begin
                        write_tag(cur, need, 1'b1);
                        write_tag(cur + need, blk_size - need, 1'b0);
                    end else begin
                        write_tag(cur, blk_size, 1'b1);
                    end
                    reply.alloc_addr = ADDR_W'((cur + 1) * GRANULE_BYTES);
                    return reply;
                end
                cur += blk_size;
            end
            reply.fail = 1'b1;
        end else begin
            while (cur < GRANULES) begin
                tag      = heap_tags[cur];
                blk_size = 32'(tag >> 1);
                pay      = (cur + 1) * GRANULE_BYTES;
                if (blk_size == 0 || pay > 32'(addr)) break;
                if (pay == 32'(addr)) begin
                    // already-free block stays as it is
                    if (tag[0]) write_tag(cur, blk_size, 1'b0);
                    break;
                end
                cur += blk_size;
            end
        end
        return reply;
    endfunction

    // Mostly back-to-back or short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Send one command word, then predict its reply at the accepting edge
    task automatic send_word(logic cmd, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr);
        int     gap;
        int     idx [$];
        t_reply reply;
        gap = pick_gap();
        if (gap > 0) begin
            start       <= 1'b0;
            i_cmd       <= 1'($urandom);
            i_req_bytes <= REQ_W'($urandom);
            i_free_addr <= ADDR_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_cmd       <= cmd;
        i_req_bytes <= req;
        i_free_addr <= addr;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        reply = heap_apply(cmd, req, addr);
        predicted_replies.push_back(reply);
        // track which payload offsets are live so releases can target them
        if (cmd == CMD_ALLOC) begin
            if (reply.fail) begin
                n_refused++;
            end else begin
                n_granted++;
                live_blocks.push_back(reply.alloc_addr);
            end
        end else begin
            n_releases++;
            idx = live_blocks.find_first_index(item) with (item == addr);
            if (idx.size() != 0) begin
                n_freed++;
                live_blocks.delete(idx[0]);
                released_blocks.push_back(addr);
            end
        end
    endtask

    // Whole-heap exact fit, full heap, bad and double releases
    task automatic test_whole_heap();
        send_word(CMD_ALLOC, REQ_W'(4080), '0);
        send_word(CMD_ALLOC, '0, '0);
        send_word(CMD_FREE, '0, ADDR_W'(4095));
        send_word(CMD_FREE, '0, ADDR_W'(8));
        send_word(CMD_FREE, '0, ADDR_W'(8));
        // leftover of one granule: whole block taken
        send_word(CMD_ALLOC, REQ_W'(4072), '0);
        send_word(CMD_FREE, '0, ADDR_W'(8));
    endtask

    // Leftover of exactly the split minimum, oversized requests
    task automatic test_split_threshold();
        send_word(CMD_ALLOC, REQ_W'(4056), '0);
        send_word(CMD_ALLOC, '0, '0);
        send_word(CMD_ALLOC, REQ_W'(8191), '0);
        send_word(CMD_ALLOC, REQ_W'(4096), '0);
        send_word(CMD_FREE, '0, ADDR_W'(4080));
        send_word(CMD_FREE, '0, ADDR_W'(4080));
        send_word(CMD_FREE, '0, '0);
        send_word(CMD_FREE, '0, ADDR_W'(8));
    endtask

    // Zero-byte and granule-edge requests, reuse of a freed hole
    task automatic test_small_requests();
        send_word(CMD_ALLOC, '0, '0);
        send_word(CMD_ALLOC, REQ_W'(1), '0);
        send_word(CMD_ALLOC, REQ_W'(8), '0);
        send_word(CMD_ALLOC, REQ_W'(9), '0);
        send_word(CMD_FREE, '0, ADDR_W'(24));
        send_word(CMD_ALLOC, REQ_W'(7), '0);
        // offset that falls inside a block, not on a payload
        send_word(CMD_FREE, '0, ADDR_W'(12));
    endtask

    function automatic logic [REQ_W-1:0] pick_request();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return REQ_W'($urandom_range(64));
        if (roll < 90) return REQ_W'($urandom_range(512, 65));
        if (roll < 95) return REQ_W'($urandom_range(4096, 513));
        return REQ_W'($urandom_range(8191, 4097));
    endfunction

    function automatic logic [ADDR_W-1:0] pick_release();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75) return live_blocks[$urandom_range(live_blocks.size() - 1)];
        if (roll < 87 && released_blocks.size() != 0)
            return released_blocks[$urandom_range(released_blocks.size() - 1)];
        return ADDR_W'($urandom_range(4095));
    endfunction

    // Mixed allocate/release traffic; release pressure rises once more than 40 blocks are live
    task automatic test_random_traffic(int count);
        int alloc_pct;
        for (int n = 0; n < count; n++) begin
            no_idle   = (n % 120) >= 90;
            alloc_pct = (live_blocks.size() > 40) ? 35 : 55;
            if (live_blocks.size() == 0 || $urandom_range(99) < alloc_pct)
                send_word(CMD_ALLOC, pick_request(), ADDR_W'($urandom));
            else
                send_word(CMD_FREE, REQ_W'($urandom), pick_release());
        end
        no_idle = 1'b0;
    endtask

    // Compare each result word with the oldest prediction
    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (predicted_replies.size() == 0) begin
                $error("result word with nothing outstanding: alloc_addr=%0d fail=%0b",
                       o_alloc_addr, o_fail);
                mismatches++;
            end else begin
                want = predicted_replies.pop_front();
                if (o_alloc_addr !== want.alloc_addr) begin
                    $error("alloc_addr: expected %0d, got %0d", want.alloc_addr, o_alloc_addr);
                    mismatches++;
                end
                if (o_fail !== want.fail) begin
                    $error("fail: expected %0b, got %0b", want.fail, o_fail);
                    mismatches++;
                end
            end
        end
    end

    // Ends the run if neither side moves a word for too long
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        start       = 1'b0;
        i_cmd       = CMD_ALLOC;
        i_req_bytes = '0;
        i_free_addr = '0;
        i_rst_n     = 1'b0;
        reset_heap();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_whole_heap();
        test_split_threshold();
        test_small_requests();
        test_random_traffic(RANDOM_WORDS);

        start <= 1'b0;
        while (predicted_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d allocates (%0d granted, %0d refused) and %0d releases",
                 n_granted + n_refused, n_granted, n_refused, n_releases);
        $display("%0d releases hit live blocks; %0d blocks still live at the end",
                 n_freed, live_blocks.size());
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
